### rtl/gem_pkg.sv
// ----------------------------------------------------------------------------
// Grid edge mapper package
// Widths, codes, pipeline word type, division step and length clamp helpers.
// ----------------------------------------------------------------------------
package gem_pkg;

  localparam int LenW     = 9;
  localparam int CoordW   = 8;
  localparam int IdxW     = 26;
  localparam int CfgIdxW  = 2;
  localparam int MaxLen   = 256;
  localparam int ProdW    = 2 * LenW;
  localparam int NW       = 3 * LenW;
  localparam int AW       = NW + 2;
  localparam int DivW     = 28;
  localparam int DivSteps = 7;
  localparam int DivStages = DivW / DivSteps;

  localparam logic [CfgIdxW-1:0] CfgLenX = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLenY = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLenZ = 2'd2;

  localparam logic [1:0] OpEdgeToVtx = 2'd0;
  localparam logic [1:0] OpPairToEdge = 2'd1;
  localparam logic [1:0] OpIdxToCoord = 2'd2;
  localparam logic [1:0] OpCoordToIdx = 2'd3;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StNadj  = 2'd1;
  localparam logic [1:0] StRange = 2'd2;

  localparam logic [1:0] AxX    = 2'd0;
  localparam logic [1:0] AxY    = 2'd1;
  localparam logic [1:0] AxZ    = 2'd2;
  localparam logic [1:0] AxNone = 2'd3;

  typedef struct packed {
    logic [1:0]                   op;
    logic [1:0]                   st;
    logic [IdxW-1:0]              idx;
    logic [2:0][CoordW-1:0]       c;
    logic [1:0]                   ax;
    logic [2:0][LenW-1:0]         l;
    logic [LenW-1:0]              r1;
    logic [ProdW-1:0]             p01;
    logic [ProdW-1:0]             p02;
    logic [ProdW-1:0]             p12;
    logic [NW-1:0]                n;
    logic [NW-1:0]                e0;
    logic [NW-1:0]                e1;
    logic [NW-1:0]                e2;
    logic [AW-1:0]                e01;
    logic [AW-1:0]                etot;
    logic [AW-1:0]                acc;
    logic                         lt_n;
    logic                         lt_e0;
    logic                         lt_e01;
  } item_t;

  typedef struct packed {
    logic [LenW-1:0] rem;
    logic [DivW-1:0] word;
  } div_t;

  // Restoring division steps: dividend bits shift out at the top of word,
  // quotient bits shift in at the bottom.
  function automatic div_t div_steps(input div_t s, input logic [LenW-1:0] dsr);
    div_t          r;
    logic [LenW:0] tmp;
    r = s;
    for (int i = 0; i < DivSteps; i++) begin
      tmp    = {r.rem, r.word[DivW-1]};
      r.word = {r.word[DivW-2:0], 1'b0};
      if (tmp >= {1'b0, dsr}) begin
        tmp       = tmp - {1'b0, dsr};
        r.word[0] = 1'b1;
      end
      r.rem = tmp[LenW-1:0];
    end
    return r;
  endfunction

  function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] v);
    logic [LenW-1:0] r;
    r = v;
    if (v == '0) r = LenW'(1);
    else if (int'(v) > MaxLen) r = LenW'(MaxLen);
    return r;
  endfunction

endpackage

### rtl/gem_div.sv
// ----------------------------------------------------------------------------
// Pipelined divider
// Unsigned restoring division, seven quotient bits per stage, with a side
// word carried along; a full stage holds when the next is full and stalled.
// ----------------------------------------------------------------------------
module gem_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [gem_pkg::DivW-1:0]    dividend_i,
  input  logic [gem_pkg::LenW-1:0]    divisor_i,
  input  gem_pkg::item_t              pay_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [gem_pkg::DivW-1:0]    quot_o,
  output logic [gem_pkg::LenW-1:0]    rem_o,
  output gem_pkg::item_t              pay_o
);
  import gem_pkg::*;

  logic [DivStages-1:0] v_q;
  logic [DivStages:0]   en;
  div_t                 st_q  [DivStages];
  logic [LenW-1:0]      dsr_q [DivStages];
  item_t                pay_q [DivStages];

  assign en[DivStages] = out_ready_i;
  assign in_ready_o    = en[0];

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    assign en[k] = !v_q[k] || en[k+1];
    if (k == 0) begin : g_first
      div_t start;
      assign start.rem  = '0;
      assign start.word = dividend_i;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) v_q[k] <= 1'b0;
        else if (en[k]) v_q[k] <= in_valid_i;
      end
      always_ff @(posedge clk_i) begin
        if (en[k]) begin
          st_q[k]  <= div_steps(start, divisor_i);
          dsr_q[k] <= divisor_i;
          pay_q[k] <= pay_i;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) v_q[k] <= 1'b0;
        else if (en[k]) v_q[k] <= v_q[k-1];
      end
      always_ff @(posedge clk_i) begin
        if (en[k]) begin
          st_q[k]  <= div_steps(st_q[k-1], dsr_q[k-1]);
          dsr_q[k] <= dsr_q[k-1];
          pay_q[k] <= pay_q[k-1];
        end
      end
    end
  end

  assign out_valid_o = v_q[DivStages-1];
  assign quot_o      = st_q[DivStages-1].word;
  assign rem_o       = st_q[DivStages-1].rem;
  assign pay_o       = pay_q[DivStages-1];

endmodule

### rtl/grid_edge_index_mapper_unit.sv
// ----------------------------------------------------------------------------
// Grid edge index mapper
// Address unit for a 3D voxel grid graph: edge index to vertices, vertex
// pair to edge index, vertex index to coordinates and back.
// ----------------------------------------------------------------------------
// Usage:
//   Write len_x, len_y, len_z (index 0..2) on the cfg port while no word is
//   in flight; each axis length is saturated to 1..256. Reset sets all three
//   to 256.
//   Query words enter on the in channel (valid/ready) and results leave on
//   the out channel (valid/ready), one result per query, in order.
//   From the accepting edge to out_valid_o a word passes through the input
//   register, five setup stages (products, edge counts, bin select), two
//   dividers of four stages each for the mixed-radix decode, and the output
//   register.
//   The unit takes one word per cycle unless stalled; every stage is a
//   register with its own valid bit, so a stalled receiver holds only the
//   stages that are full and bubbles still close up behind it. in_ready_o
//   drops once the receiver stalls and every stage up to the input is full.
//   Reset empties the pipeline; out_valid_o is low until a word drains out.
//   Status 2 flags an index or coordinate out of range, status 1 a vertex
//   pair that is not adjacent; with a nonzero status all other fields are 0.
// ----------------------------------------------------------------------------
module grid_edge_index_mapper_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gem_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [gem_pkg::LenW-1:0]        cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      req_type_i,
  input  logic [gem_pkg::IdxW-1:0]        index_in_i,
  input  logic [gem_pkg::CoordW-1:0]      a_x_i,
  input  logic [gem_pkg::CoordW-1:0]      a_y_i,
  input  logic [gem_pkg::CoordW-1:0]      a_z_i,
  input  logic [gem_pkg::CoordW-1:0]      b_x_i,
  input  logic [gem_pkg::CoordW-1:0]      b_y_i,
  input  logic [gem_pkg::CoordW-1:0]      b_z_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [gem_pkg::IdxW-1:0]        index_out_o,
  output logic [gem_pkg::CoordW-1:0]      src_x_o,
  output logic [gem_pkg::CoordW-1:0]      src_y_o,
  output logic [gem_pkg::CoordW-1:0]      src_z_o,
  output logic [gem_pkg::CoordW-1:0]      tgt_x_o,
  output logic [gem_pkg::CoordW-1:0]      tgt_y_o,
  output logic [gem_pkg::CoordW-1:0]      tgt_z_o,
  output logic [1:0]                      axis_o,
  output logic [1:0]                      status_o
);
  import gem_pkg::*;

  typedef struct packed {
    logic [1:0]             op;
    logic [IdxW-1:0]        idx;
    logic [2:0][CoordW-1:0] a;
    logic [2:0][CoordW-1:0] b;
  } in_t;

  // configuration
  logic [LenW-1:0] len_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q[0] <= LenW'(256);
      len_q[1] <= LenW'(256);
      len_q[2] <= LenW'(256);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLenX: len_q[0] <= cfg_data_i;
        CfgLenY: len_q[1] <= cfg_data_i;
        CfgLenZ: len_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage valids and enables
  logic       v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic       en1, en2, en3, en4, en5, en6;
  logic       diva_ready, diva_valid, divb_ready, divb_valid;
  logic       ov_q, en_out;
  in_t        in1_q;
  item_t      it2_d, it2_q, it3_d, it3_q, it4_d, it4_q, it5_d, it5_q, it6_d, it6_q;
  item_t      diva_pay_d, diva_pay, divb_pay_d, divb_pay;
  logic [DivW-1:0] diva_dvd, diva_quot, divb_quot;
  logic [LenW-1:0] diva_dsr, diva_rem, divb_rem;

  assign en_out     = !ov_q || out_ready_i;
  assign en6        = !v6_q || diva_ready;
  assign en5        = !v5_q || en6;
  assign en4        = !v4_q || en5;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (en1)    v1_q <= in_valid_i;
      if (en2)    v2_q <= v1_q;
      if (en3)    v3_q <= v2_q;
      if (en4)    v4_q <= v3_q;
      if (en5)    v5_q <= v4_q;
      if (en6)    v6_q <= v5_q;
      if (en_out) ov_q <= divb_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      in1_q.op  <= req_type_i;
      in1_q.idx <= index_in_i;
      in1_q.a   <= {a_z_i, a_y_i, a_x_i};
      in1_q.b   <= {b_z_i, b_y_i, b_x_i};
    end
    if (en2) it2_q <= it2_d;
    if (en3) it3_q <= it3_d;
    if (en4) it4_q <= it4_d;
    if (en5) it5_q <= it5_d;
    if (en6) it6_q <= it6_d;
  end

  // stage 1: clamp lengths, range and adjacency checks, pair products
  logic [2:0][LenW-1:0]   l1;
  logic [2:0][CoordW-1:0] df, smin;
  logic [2:0]             nz, one;
  logic                   rng_a, rng_b, adj;
  logic [1:0]             ax1;

  always_comb begin
    rng_a = 1'b0;
    rng_b = 1'b0;
    for (int d = 0; d < 3; d++) begin
      l1[d]   = clamp_len(len_q[d]);
      if ({1'b0, in1_q.a[d]} >= l1[d]) rng_a = 1'b1;
      if ({1'b0, in1_q.b[d]} >= l1[d]) rng_b = 1'b1;
      df[d]   = (in1_q.a[d] > in1_q.b[d]) ? in1_q.a[d] - in1_q.b[d]
                                          : in1_q.b[d] - in1_q.a[d];
      smin[d] = (in1_q.a[d] > in1_q.b[d]) ? in1_q.b[d] : in1_q.a[d];
      nz[d]   = df[d] != '0;
      one[d]  = df[d] == CoordW'(1);
    end
    // Manhattan distance one: a single axis differs, by one
    adj = (nz == 3'b001 && one[0]) || (nz == 3'b010 && one[1]) ||
          (nz == 3'b100 && one[2]);
    ax1 = nz[2] ? AxZ : (nz[1] ? AxY : AxX);

    it2_d     = '0;
    it2_d.op  = in1_q.op;
    it2_d.idx = in1_q.idx;
    it2_d.l   = l1;
    it2_d.p01 = ProdW'(l1[0]) * ProdW'(l1[1]);
    it2_d.p02 = ProdW'(l1[0]) * ProdW'(l1[2]);
    it2_d.p12 = ProdW'(l1[1]) * ProdW'(l1[2]);
    it2_d.st  = StOk;
    it2_d.c   = in1_q.a;
    it2_d.ax  = AxX;
    case (in1_q.op)
      OpPairToEdge: begin
        it2_d.c  = smin;
        it2_d.ax = ax1;
        if (rng_a || rng_b) it2_d.st = StRange;
        else if (!adj) it2_d.st = StNadj;
      end
      OpCoordToIdx: begin
        if (rng_a) it2_d.st = StRange;
      end
      default: ;
    endcase
  end

  // stage 2: vertex count, inner mixed-radix term
  logic [LenW-1:0] mr_r1, mr_r0;

  always_comb begin
    it3_d     = it2_q;
    mr_r1     = it2_q.l[1];
    if (it2_q.op == OpPairToEdge && it2_q.ax == AxY) mr_r1 = it2_q.l[1] - LenW'(1);
    it3_d.n   = NW'(it2_q.p01) * NW'(it2_q.l[2]);
    it3_d.acc = AW'(mr_r1) * AW'(it2_q.c[2]) + AW'(it2_q.c[1]);
  end

  // stage 3: edge counts per axis, outer mixed-radix term
  always_comb begin
    it4_d      = it3_q;
    mr_r0      = it3_q.l[0];
    if (it3_q.op == OpPairToEdge && it3_q.ax == AxX) mr_r0 = it3_q.l[0] - LenW'(1);
    it4_d.e0   = it3_q.n - NW'(it3_q.p12);
    it4_d.e1   = it3_q.n - NW'(it3_q.p02);
    it4_d.e2   = it3_q.n - NW'(it3_q.p01);
    it4_d.acc  = AW'(mr_r0) * it3_q.acc + AW'(it3_q.c[0]);
    it4_d.lt_n = NW'(it3_q.idx) < it3_q.n;
  end

  // stage 4: first bin boundary
  always_comb begin
    it5_d       = it4_q;
    it5_d.e01   = AW'(it4_q.e0) + AW'(it4_q.e1);
    it5_d.lt_e0 = NW'(it4_q.idx) < it4_q.e0;
  end

  // stage 5: total edge count, bin base for the pair query
  always_comb begin
    it6_d        = it5_q;
    it6_d.etot   = it5_q.e01 + AW'(it5_q.e2);
    it6_d.lt_e01 = AW'(it5_q.idx) < it5_q.e01;
    if (it5_q.op == OpPairToEdge) begin
      case (it5_q.ax)
        AxY:     it6_d.acc = it5_q.acc + AW'(it5_q.e0);
        AxZ:     it6_d.acc = it5_q.acc + it5_q.e01;
        default: it6_d.acc = it5_q.acc;
      endcase
    end
  end

  // stage 6: pick the bin, offset and radices for the decode
  logic [AW-1:0]   off, base;
  logic [1:0]      red, axe;
  logic [LenW-1:0] dr0, dr1;

  always_comb begin
    diva_pay_d = it6_q;
    off        = '0;
    base       = '0;
    red        = AxNone;
    axe        = it6_q.lt_e0 ? AxX : (it6_q.lt_e01 ? AxY : AxZ);
    case (axe)
      AxY:     base = AW'(it6_q.e0);
      AxZ:     base = it6_q.e01;
      default: base = '0;
    endcase
    case (it6_q.op)
      OpEdgeToVtx: begin
        if (!(AW'(it6_q.idx) < it6_q.etot)) diva_pay_d.st = StRange;
        diva_pay_d.ax = axe;
        red           = axe;
        off           = AW'(it6_q.idx) - base;
      end
      OpIdxToCoord: begin
        if (!it6_q.lt_n) diva_pay_d.st = StRange;
        off = AW'(it6_q.idx);
      end
      default: ;
    endcase
    dr0 = it6_q.l[0];
    dr1 = it6_q.l[1];
    if (red == AxX) dr0 = it6_q.l[0] - LenW'(1);
    if (red == AxY) dr1 = it6_q.l[1] - LenW'(1);
    if (dr0 == '0) dr0 = LenW'(1);
    if (dr1 == '0) dr1 = LenW'(1);
    diva_pay_d.r1 = dr1;
    diva_dvd      = DivW'(off);
    diva_dsr      = dr0;
  end

  gem_div u_diva (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v6_q),
    .in_ready_o  (diva_ready),
    .dividend_i  (diva_dvd),
    .divisor_i   (diva_dsr),
    .pay_i       (diva_pay_d),
    .out_valid_o (diva_valid),
    .out_ready_i (divb_ready),
    .quot_o      (diva_quot),
    .rem_o       (diva_rem),
    .pay_o       (diva_pay)
  );

  always_comb begin
    divb_pay_d      = diva_pay;
    divb_pay_d.c[0] = diva_rem[CoordW-1:0];
  end

  gem_div u_divb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (diva_valid),
    .in_ready_o  (divb_ready),
    .dividend_i  (diva_quot),
    .divisor_i   (diva_pay.r1),
    .pay_i       (divb_pay_d),
    .out_valid_o (divb_valid),
    .out_ready_i (en_out),
    .quot_o      (divb_quot),
    .rem_o       (divb_rem),
    .pay_o       (divb_pay)
  );

  // output register
  logic [IdxW-1:0]        idx_d, idx_q;
  logic [2:0][CoordW-1:0] src_d, src_q, tgt_d, tgt_q, dec;
  logic [1:0]             ax_d, ax_q, st_d, st_q;

  always_comb begin
    dec   = {divb_quot[CoordW-1:0], divb_rem[CoordW-1:0], divb_pay.c[0]};
    idx_d = '0;
    src_d = '0;
    tgt_d = '0;
    ax_d  = '0;
    st_d  = divb_pay.st;
    if (divb_pay.st == StOk) begin
      case (divb_pay.op)
        OpEdgeToVtx: begin
          src_d = dec;
          tgt_d = dec;
          ax_d  = divb_pay.ax;
          case (divb_pay.ax)
            AxY:     tgt_d[1] = dec[1] + CoordW'(1);
            AxZ:     tgt_d[2] = dec[2] + CoordW'(1);
            default: tgt_d[0] = dec[0] + CoordW'(1);
          endcase
        end
        OpPairToEdge: begin
          idx_d = divb_pay.acc[IdxW-1:0];
          ax_d  = divb_pay.ax;
        end
        OpIdxToCoord: src_d = dec;
        default:      idx_d = divb_pay.acc[IdxW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      idx_q <= idx_d;
      src_q <= src_d;
      tgt_q <= tgt_d;
      ax_q  <= ax_d;
      st_q  <= st_d;
    end
  end

  assign out_valid_o = ov_q;
  assign index_out_o = idx_q;
  assign src_x_o     = src_q[0];
  assign src_y_o     = src_q[1];
  assign src_z_o     = src_q[2];
  assign tgt_x_o     = tgt_q[0];
  assign tgt_y_o     = tgt_q[1];
  assign tgt_z_o     = tgt_q[2];
  assign axis_o      = ax_q;
  assign status_o    = st_q;

endmodule

### rtl/gem_chk.sv
// ----------------------------------------------------------------------------
// Grid edge mapper port checker
// Watches the top level's ports and flags results that break the contract.
// ----------------------------------------------------------------------------
module gem_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_we_i,
  input logic [gem_pkg::CfgIdxW-1:0] cfg_idx_i,
  input logic [gem_pkg::LenW-1:0]    cfg_data_i,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [1:0]                  req_type_i,
  input logic [gem_pkg::IdxW-1:0]    index_in_i,
  input logic [gem_pkg::CoordW-1:0]  a_x_i,
  input logic [gem_pkg::CoordW-1:0]  a_y_i,
  input logic [gem_pkg::CoordW-1:0]  a_z_i,
  input logic [gem_pkg::CoordW-1:0]  b_x_i,
  input logic [gem_pkg::CoordW-1:0]  b_y_i,
  input logic [gem_pkg::CoordW-1:0]  b_z_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [gem_pkg::IdxW-1:0]    index_out_o,
  input logic [gem_pkg::CoordW-1:0]  src_x_o,
  input logic [gem_pkg::CoordW-1:0]  src_y_o,
  input logic [gem_pkg::CoordW-1:0]  src_z_o,
  input logic [gem_pkg::CoordW-1:0]  tgt_x_o,
  input logic [gem_pkg::CoordW-1:0]  tgt_y_o,
  input logic [gem_pkg::CoordW-1:0]  tgt_z_o,
  input logic [1:0]                  axis_o,
  input logic [1:0]                  status_o
);
  import gem_pkg::*;

  // a stalled result stays valid; its index, src_x, tgt_z, axis and status hold
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(index_out_o) &&
    $stable(src_x_o) && $stable(tgt_z_o) && $stable(axis_o) && $stable(status_o))
    else $error("stalled result changed");

  // an error word carries nothing but its status
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StOk |-> index_out_o == '0 && src_x_o == '0 &&
    src_y_o == '0 && src_z_o == '0 && tgt_x_o == '0 && tgt_y_o == '0 &&
    tgt_z_o == '0 && axis_o == AxX)
    else $error("error result with nonzero fields");

  a_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> axis_o != AxNone && status_o != 2'd3)
    else $error("axis or status code out of range");

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid out of reset");

endmodule

bind grid_edge_index_mapper_unit gem_chk u_gem_chk (.*);

### tb/grid_edge_index_checker.sv
// ----------------------------------------------------------------------------
// Grid edge mapper result checker
// Watches the config port and both channels, predicts every accepted query
// from its own copy of the axis lengths and compares each result in order.
// ----------------------------------------------------------------------------
module grid_edge_index_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gem_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [gem_pkg::LenW-1:0]        cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [1:0]                      req_type_i,
  input  logic [gem_pkg::IdxW-1:0]        index_in_i,
  input  logic [gem_pkg::CoordW-1:0]      a_x_i,
  input  logic [gem_pkg::CoordW-1:0]      a_y_i,
  input  logic [gem_pkg::CoordW-1:0]      a_z_i,
  input  logic [gem_pkg::CoordW-1:0]      b_x_i,
  input  logic [gem_pkg::CoordW-1:0]      b_y_i,
  input  logic [gem_pkg::CoordW-1:0]      b_z_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [gem_pkg::IdxW-1:0]        index_out_i,
  input  logic [gem_pkg::CoordW-1:0]      src_x_i,
  input  logic [gem_pkg::CoordW-1:0]      src_y_i,
  input  logic [gem_pkg::CoordW-1:0]      src_z_i,
  input  logic [gem_pkg::CoordW-1:0]      tgt_x_i,
  input  logic [gem_pkg::CoordW-1:0]      tgt_y_i,
  input  logic [gem_pkg::CoordW-1:0]      tgt_z_i,
  input  logic [1:0]                      axis_i,
  input  logic [1:0]                      status_i,
  output int                              pending_o,
  output int                              checked_o,
  output int                              fail_count_o
);
  import gem_pkg::*;

  typedef struct packed {
    logic [IdxW-1:0]   idx;
    logic [CoordW-1:0] sx, sy, sz, tx, ty, tz;
    logic [1:0]        ax;
    logic [1:0]        st;
  } answer_t;

  typedef longint unsigned u64_t;

  logic [LenW-1:0] grid_len [3];
  answer_t         answers_q [$];
  int              mismatches;

  assign pending_o    = answers_q.size();
  assign fail_count_o = mismatches;

  function automatic u64_t sat_len(input logic [LenW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxLen) return MaxLen;
    return u64_t'(v);
  endfunction

  function automatic u64_t vtx_offset(input u64_t c[3], input u64_t l[3], input int red);
    u64_t acc, mul;
    acc = 0;
    mul = 1;
    for (int d = 0; d < 3; d++) begin
      acc += c[d] * mul;
      mul *= (d == red) ? l[d] - 1 : l[d];
    end
    return acc;
  endfunction

  function automatic answer_t map_query(input logic [1:0] op, input logic [IdxW-1:0] qi,
                                        input u64_t a[3], input u64_t b[3]);
    answer_t r;
    u64_t    l[3], e[3], s[3], t[3];
    u64_t    n, idx, dv, rad, hops, base, df;
    int      ax;
    r = '0;
    for (int d = 0; d < 3; d++) l[d] = sat_len(grid_len[d]);
    n = l[0] * l[1] * l[2];
    for (int d = 0; d < 3; d++) e[d] = n - n / l[d];
    idx = u64_t'(qi);
    ax = 0;
    case (op)
      OpEdgeToVtx: begin
        if (idx >= e[0] + e[1] + e[2]) begin
          r.st = StRange;
          return r;
        end
        while (ax < 2 && idx >= e[ax]) begin
          idx -= e[ax];
          ax++;
        end
        dv = 1;
        for (int d = 0; d < 3; d++) begin
          rad = (d == ax) ? l[d] - 1 : l[d];
          if (rad == 0) rad = 1;
          s[d] = (idx / dv) % rad;
          dv *= rad;
          t[d] = s[d];
        end
        t[ax] += 1;
        r.sx = CoordW'(s[0]); r.sy = CoordW'(s[1]); r.sz = CoordW'(s[2]);
        r.tx = CoordW'(t[0]); r.ty = CoordW'(t[1]); r.tz = CoordW'(t[2]);
        r.ax = 2'(ax);
      end
      OpPairToEdge: begin
        for (int d = 0; d < 3; d++)
          if (a[d] >= l[d] || b[d] >= l[d]) begin
            r.st = StRange;
            return r;
          end
        if (vtx_offset(b, l, 3) < vtx_offset(a, l, 3)) begin
          s = b; t = a;
        end else begin
          s = a; t = b;
        end
        hops = 0;
        for (int d = 0; d < 3; d++) begin
          df = (s[d] > t[d]) ? s[d] - t[d] : t[d] - s[d];
          hops += df;
          if (df != 0) ax = d;
        end
        if (hops != 1) begin
          r.st = StNadj;
          return r;
        end
        base = 0;
        for (int d = 0; d < ax; d++) base += e[d];
        r.idx = IdxW'(base + vtx_offset(s, l, ax));
        r.ax  = 2'(ax);
      end
      OpIdxToCoord: begin
        if (idx >= n) begin
          r.st = StRange;
          return r;
        end
        r.sx = CoordW'(idx % l[0]);
        r.sy = CoordW'((idx / l[0]) % l[1]);
        r.sz = CoordW'((idx / (l[0] * l[1])) % l[2]);
      end
      default: begin
        for (int d = 0; d < 3; d++)
          if (a[d] >= l[d]) begin
            r.st = StRange;
            return r;
          end
        r.idx = IdxW'(vtx_offset(a, l, 3));
      end
    endcase
    r.st = StOk;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want, got;
    u64_t    qa[3], qb[3];
    if (!rst_ni) begin
      for (int d = 0; d < 3; d++) grid_len[d] <= LenW'(MaxLen);
      answers_q.delete();
      mismatches = 0;
      checked_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgLenX: grid_len[0] <= cfg_data_i;
          CfgLenY: grid_len[1] <= cfg_data_i;
          CfgLenZ: grid_len[2] <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        qa[0] = u64_t'(a_x_i); qa[1] = u64_t'(a_y_i); qa[2] = u64_t'(a_z_i);
        qb[0] = u64_t'(b_x_i); qb[1] = u64_t'(b_y_i); qb[2] = u64_t'(b_z_i);
        answers_q = {answers_q, map_query(req_type_i, index_in_i, qa, qb)};
      end
      if (out_valid_i && out_ready_i) begin
        got = '{index_out_i, src_x_i, src_y_i, src_z_i, tgt_x_i, tgt_y_i, tgt_z_i,
                axis_i, status_i};
        if (answers_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", got);
        end else begin
          want = answers_q.pop_front();
          checked_o++;
          if (got.idx !== want.idx || got.sx !== want.sx || got.sy !== want.sy ||
              got.sz !== want.sz || got.tx !== want.tx || got.ty !== want.ty ||
              got.tz !== want.tz || got.ax !== want.ax || got.st !== want.st) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: idx %0d/%0d src %0d,%0d,%0d/%0d,%0d,%0d tgt %0d,%0d,%0d/%0d,%0d,%0d ax %0d/%0d st %0d/%0d (got/exp)",
                       got.idx, want.idx, got.sx, got.sy, got.sz, want.sx, want.sy, want.sz,
                       got.tx, got.ty, got.tz, want.tx, want.ty, want.tz,
                       got.ax, want.ax, got.st, want.st);
          end
        end
      end
    end
  end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Grid edge mapper testbench
// Directed corner queries at two shapes, then random queries over several
// grid shapes and handshake pressure phases; the checker does the compare.
// ----------------------------------------------------------------------------
module testbench;
  import gem_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgLenX;
  logic [LenW-1:0]   cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        req_type_i = OpEdgeToVtx;
  logic [IdxW-1:0]   index_in_i = '0;
  logic [CoordW-1:0] a_x_i = '0, a_y_i = '0, a_z_i = '0;
  logic [CoordW-1:0] b_x_i = '0, b_y_i = '0, b_z_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [IdxW-1:0]   index_out_o;
  logic [CoordW-1:0] src_x_o, src_y_o, src_z_o, tgt_x_o, tgt_y_o, tgt_z_o;
  logic [1:0]        axis_o, status_o;
  int                pending, checked, fails;
  int                idle_pct = 0, stall_pct = 0;
  int                len_eff [3];

  always #10 clk_i = ~clk_i;

  grid_edge_index_mapper_unit dut (.*);

  grid_edge_index_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .req_type_i, .index_in_i,
    .a_x_i, .a_y_i, .a_z_i, .b_x_i, .b_y_i, .b_z_i,
    .out_valid_i(out_valid_o), .out_ready_i, .index_out_i(index_out_o),
    .src_x_i(src_x_o), .src_y_i(src_y_o), .src_z_i(src_z_o),
    .tgt_x_i(tgt_x_o), .tgt_y_i(tgt_y_o), .tgt_z_i(tgt_z_o),
    .axis_i(axis_o), .status_i(status_o),
    .pending_o(pending), .checked_o(checked), .fail_count_o(fails)
  );

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= stall_pct);

  initial begin
    #(20 * 400000);
    $display("status: fail");
    $finish;
  end

  task automatic send_word(input logic [1:0] op, input logic [IdxW-1:0] idx,
                           input logic [CoordW-1:0] ax, ay, az, bx, by, bz);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= op;
    index_in_i <= idx;
    a_x_i <= ax; a_y_i <= ay; a_z_i <= az;
    b_x_i <= bx; b_y_i <= by; b_z_i <= bz;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drain, let the pipeline empty, then write all three lengths.
  task automatic set_grid(input logic [LenW-1:0] lx, ly, lz);
    logic [LenW-1:0] raw [3];
    raw = '{lx, ly, lz};
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    for (int d = 0; d < 3; d++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= (d == 0) ? CfgLenX : (d == 1) ? CfgLenY : CfgLenZ;
      cfg_data_i <= raw[d];
      @(posedge clk_i);
      len_eff[d] = (raw[d] == 0) ? 1 : (raw[d] > MaxLen) ? MaxLen : raw[d];
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [CoordW-1:0] pick_coord(input int d);
    if ($urandom_range(9) == 0) return CoordW'($urandom);
    return CoordW'($urandom_range(len_eff[d] - 1));
  endfunction

  task automatic random_word();
    logic [1:0]        op;
    logic [CoordW-1:0] a [3], b [3];
    logic [IdxW-1:0]   idx;
    int                n, ax;
    n = len_eff[0] * len_eff[1] * len_eff[2];
    op = 2'($urandom_range(3));
    for (int d = 0; d < 3; d++) begin
      a[d] = pick_coord(d);
      b[d] = pick_coord(d);
    end
    case ($urandom_range(9))
      0: idx = IdxW'($urandom);
      1: idx = IdxW'(3 * n - $urandom_range(3));
      default: idx = IdxW'($urandom_range(3 * n));
    endcase
    // Mostly adjacent pairs so the edge numbering gets exercised.
    if (op == OpPairToEdge && $urandom_range(9) < 7) begin
      ax = $urandom_range(2);
      b = a;
      if ($urandom_range(1) == 1 && a[ax] + 1 < len_eff[ax]) b[ax] = a[ax] + 1;
      else if (a[ax] > 0) b[ax] = a[ax] - 1;
    end
    send_word(op, idx, a[0], a[1], a[2], b[0], b[1], b[2]);
  endtask

  initial begin
    int idle_tab [4] = '{0, 83, 0, 37};
    int stall_tab [4] = '{0, 0, 83, 37};
    logic [LenW-1:0] shapes [8][3] = '{
      '{9'd1, 9'd1, 9'd1}, '{9'd3, 9'd5, 9'd2}, '{9'd0, 9'd511, 9'd257},
      '{9'd2, 9'd1, 9'd256}, '{9'd256, 9'd256, 9'd256}, '{9'd7, 9'd1, 9'd4},
      '{9'd1, 9'd200, 9'd1}, '{9'd16, 9'd9, 9'd12}};
    len_eff = '{MaxLen, MaxLen, MaxLen};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corners at the reset shape 256^3, then at 4x3x2.
    send_word(OpEdgeToVtx, '0, 0, 0, 0, 0, 0, 0);
    send_word(OpEdgeToVtx, IdxW'(16711679), 0, 0, 0, 0, 0, 0);
    send_word(OpEdgeToVtx, IdxW'(16711680), 0, 0, 0, 0, 0, 0);
    send_word(OpEdgeToVtx, IdxW'(50135039), 0, 0, 0, 0, 0, 0);
    send_word(OpEdgeToVtx, IdxW'(50135040), 0, 0, 0, 0, 0, 0);
    send_word(OpEdgeToVtx, '1, 0, 0, 0, 0, 0, 0);
    send_word(OpIdxToCoord, IdxW'(16777215), 0, 0, 0, 0, 0, 0);
    send_word(OpIdxToCoord, IdxW'(16777216), 0, 0, 0, 0, 0, 0);
    send_word(OpIdxToCoord, '0, 0, 0, 0, 0, 0, 0);
    send_word(OpCoordToIdx, '0, 255, 255, 255, 0, 0, 0);
    send_word(OpCoordToIdx, '1, 0, 0, 0, 255, 255, 255);
    send_word(OpPairToEdge, '0, 255, 255, 255, 255, 255, 254);
    send_word(OpPairToEdge, '0, 1, 0, 0, 0, 0, 0);
    send_word(OpPairToEdge, '0, 0, 7, 0, 0, 6, 0);
    send_word(OpPairToEdge, '0, 9, 9, 9, 9, 9, 9);
    send_word(OpPairToEdge, '0, 0, 0, 0, 1, 1, 0);
    send_word(OpPairToEdge, '0, 0, 0, 0, 2, 0, 0);
    send_word(OpPairToEdge, '0, 255, 0, 0, 0, 255, 0);
    set_grid(9'd4, 9'd3, 9'd2);
    send_word(OpPairToEdge, '0, 4, 0, 0, 3, 0, 0);
    send_word(OpCoordToIdx, '0, 3, 2, 2, 0, 0, 0);
    send_word(OpEdgeToVtx, IdxW'(45), 0, 0, 0, 0, 0, 0);
    send_word(OpEdgeToVtx, IdxW'(46), 0, 0, 0, 0, 0, 0);

    for (int p = 0; p < 8; p++) begin
      set_grid(shapes[p][0], shapes[p][1], shapes[p][2]);
      for (int ph = 0; ph < 4; ph++) begin
        idle_pct  = idle_tab[ph];
        stall_pct = stall_tab[ph];
        repeat (23) random_word();
      end
    end
    idle_pct  = 0;
    stall_pct = 0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    $display("checked %0d results over 9 grid shapes, all four query kinds", checked);
    $display("with idle sender, stalled receiver and both; %0d mismatches", fails);
    if (fails == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
